@@ design/hvk_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and microcode for the height/velocity Kalman filter.
package hvk_pkg;

   localparam int STATE_WIDTH_DEF = 48;

   // Field widths of the request and response, and the internal fraction width.
   localparam int DT_W    = 24;
   localparam int Q16_W   = 32;
   localparam int FRAC_W  = 24;

   // Register file of the configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_HEIGHT_NOISE   = 3'd0;
   localparam logic [2:0] REG_VELOCITY_NOISE = 3'd1;
   localparam logic [2:0] REG_MEAS_NOISE     = 3'd2;
   localparam logic [2:0] REG_WARMUP_STEPS   = 3'd3;
   localparam logic [2:0] REG_ACCEL_DEADBAND = 3'd4;

   localparam logic [31:0] HEIGHT_NOISE_RST   = 32'd16777;
   localparam logic [31:0] VELOCITY_NOISE_RST = 32'd167772;
   localparam logic [31:0] MEAS_NOISE_RST     = 32'd8388608;
   localparam logic [15:0] WARMUP_STEPS_RST   = 16'd4500;
   localparam logic [30:0] ACCEL_DEADBAND_RST = 31'd3277;

   localparam logic [6:0]  WARMUP_BOOST = 7'd100;
   localparam logic [16:0] STEP_MAX     = 17'h1FFFF;

   typedef struct packed {
      logic [31:0] height_noise;
      logic [31:0] velocity_noise;
      logic [31:0] meas_noise;
      logic [15:0] warmup_steps;
      logic [30:0] accel_deadband;
   } hvk_cfg_type;

   // Micro-operation kinds
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MAC = 3'd2,
      OP_MSC = 3'd3,
      OP_DIV = 3'd4
   } hvk_op_type;

   // Operand and destination registers of the working set
   typedef enum logic [4:0] {
      SRC_DT   = 5'd0,  SRC_ACC  = 5'd1,  SRC_UN   = 5'd2,  SRC_HDT2 = 5'd3,
      SRC_HS   = 5'd4,  SRC_VS   = 5'd5,  SRC_PH   = 5'd6,  SRC_HV   = 5'd7,
      SRC_VH   = 5'd8,  SRC_PV   = 5'd9,  SRC_QH   = 5'd10, SRC_QV   = 5'd11,
      SRC_R    = 5'd12, SRC_ZN   = 5'd13, SRC_HP   = 5'd14, SRC_VP   = 5'd15,
      SRC_Q00  = 5'd16, SRC_Q01  = 5'd17, SRC_Q10  = 5'd18, SRC_Q11  = 5'd19,
      SRC_K0   = 5'd20, SRC_K1   = 5'd21, SRC_DIFF = 5'd22, SRC_OMK  = 5'd23,
      SRC_ONE  = 5'd24, SRC_L    = 5'd25
   } hvk_src_type;

   typedef struct packed {
      hvk_op_type  op;
      logic        clr;    // start a new sum
      logic        last;   // store saturated sum (or quotient) to dst
      hvk_src_type a;
      hvk_src_type b;
      logic        sh25;   // product rounded at 25 fraction bits
      hvk_src_type dst;
      logic        brk;    // skip to the copy section when no barometer
      logic        fin;
   } hvk_uop_type;

   localparam int PC_W = 6;
   localparam logic [PC_W-1:0] COPY_PC = 6'd34;

   function automatic hvk_uop_type uop(input hvk_op_type op, input logic clr,
                                       input logic last, input hvk_src_type a,
                                       input hvk_src_type b, input logic sh25,
                                       input hvk_src_type dst, input logic brk,
                                       input logic fin);
      hvk_uop_type u;
      u.op = op; u.clr = clr; u.last = last; u.a = a; u.b = b;
      u.sh25 = sh25; u.dst = dst; u.brk = brk; u.fin = fin;
      return u;
   endfunction

   // Step program: prediction, then update or plain copy of the prediction.
   function automatic hvk_uop_type hvk_ucode(input logic [PC_W-1:0] pc);
      hvk_uop_type u;
      case (pc)
         6'd0:  u = uop(OP_MAC, 1, 1, SRC_DT,   SRC_DT,   1, SRC_HDT2, 0, 0);
         6'd1:  u = uop(OP_ADD, 1, 0, SRC_HS,   SRC_DT,   0, SRC_HP,   0, 0);
         6'd2:  u = uop(OP_MAC, 0, 0, SRC_DT,   SRC_VS,   0, SRC_HP,   0, 0);
         6'd3:  u = uop(OP_MAC, 0, 1, SRC_HDT2, SRC_UN,   0, SRC_HP,   0, 0);
         6'd4:  u = uop(OP_ADD, 1, 0, SRC_VS,   SRC_DT,   0, SRC_VP,   0, 0);
         6'd5:  u = uop(OP_MAC, 0, 1, SRC_DT,   SRC_ACC,  0, SRC_VP,   0, 0);
         6'd6:  u = uop(OP_ADD, 1, 0, SRC_HV,   SRC_DT,   0, SRC_Q01,  0, 0);
         6'd7:  u = uop(OP_MAC, 0, 1, SRC_DT,   SRC_PV,   0, SRC_Q01,  0, 0);
         6'd8:  u = uop(OP_ADD, 1, 0, SRC_VH,   SRC_DT,   0, SRC_Q10,  0, 0);
         6'd9:  u = uop(OP_MAC, 0, 1, SRC_DT,   SRC_PV,   0, SRC_Q10,  0, 0);
         6'd10: u = uop(OP_ADD, 1, 0, SRC_PH,   SRC_DT,   0, SRC_Q00,  0, 0);
         6'd11: u = uop(OP_MAC, 0, 0, SRC_DT,   SRC_VH,   0, SRC_Q00,  0, 0);
         6'd12: u = uop(OP_MAC, 0, 0, SRC_DT,   SRC_Q01,  0, SRC_Q00,  0, 0);
         6'd13: u = uop(OP_ADD, 0, 1, SRC_QH,   SRC_DT,   0, SRC_Q00,  0, 0);
         6'd14: u = uop(OP_ADD, 1, 0, SRC_PV,   SRC_DT,   0, SRC_Q11,  0, 0);
         6'd15: u = uop(OP_ADD, 0, 1, SRC_QV,   SRC_DT,   0, SRC_Q11,  1, 0);
         6'd16: u = uop(OP_ADD, 1, 0, SRC_Q00,  SRC_DT,   0, SRC_L,    0, 0);
         6'd17: u = uop(OP_ADD, 0, 1, SRC_R,    SRC_DT,   0, SRC_L,    0, 0);
         6'd18: u = uop(OP_DIV, 1, 1, SRC_Q00,  SRC_L,    0, SRC_K0,   0, 0);
         6'd19: u = uop(OP_DIV, 1, 1, SRC_Q10,  SRC_L,    0, SRC_K1,   0, 0);
         6'd20: u = uop(OP_ADD, 1, 0, SRC_ZN,   SRC_DT,   0, SRC_DIFF, 0, 0);
         6'd21: u = uop(OP_SUB, 0, 1, SRC_HP,   SRC_DT,   0, SRC_DIFF, 0, 0);
         6'd22: u = uop(OP_ADD, 1, 0, SRC_ONE,  SRC_DT,   0, SRC_OMK,  0, 0);
         6'd23: u = uop(OP_SUB, 0, 1, SRC_K0,   SRC_DT,   0, SRC_OMK,  0, 0);
         6'd24: u = uop(OP_ADD, 1, 0, SRC_HP,   SRC_DT,   0, SRC_HS,   0, 0);
         6'd25: u = uop(OP_MAC, 0, 1, SRC_K0,   SRC_DIFF, 0, SRC_HS,   0, 0);
         6'd26: u = uop(OP_ADD, 1, 0, SRC_VP,   SRC_DT,   0, SRC_VS,   0, 0);
         6'd27: u = uop(OP_MAC, 0, 1, SRC_K1,   SRC_DIFF, 0, SRC_VS,   0, 0);
         6'd28: u = uop(OP_MAC, 1, 1, SRC_OMK,  SRC_Q00,  0, SRC_PH,   0, 0);
         6'd29: u = uop(OP_MAC, 1, 1, SRC_OMK,  SRC_Q01,  0, SRC_HV,   0, 0);
         6'd30: u = uop(OP_ADD, 1, 0, SRC_Q10,  SRC_DT,   0, SRC_VH,   0, 0);
         6'd31: u = uop(OP_MSC, 0, 1, SRC_K1,   SRC_Q00,  0, SRC_VH,   0, 0);
         6'd32: u = uop(OP_ADD, 1, 0, SRC_Q11,  SRC_DT,   0, SRC_PV,   0, 0);
         6'd33: u = uop(OP_MSC, 0, 1, SRC_K1,   SRC_Q01,  0, SRC_PV,   0, 1);
         6'd34: u = uop(OP_ADD, 1, 1, SRC_HP,   SRC_DT,   0, SRC_HS,   0, 0);
         6'd35: u = uop(OP_ADD, 1, 1, SRC_VP,   SRC_DT,   0, SRC_VS,   0, 0);
         6'd36: u = uop(OP_ADD, 1, 1, SRC_Q00,  SRC_DT,   0, SRC_PH,   0, 0);
         6'd37: u = uop(OP_ADD, 1, 1, SRC_Q01,  SRC_DT,   0, SRC_HV,   0, 0);
         6'd38: u = uop(OP_ADD, 1, 1, SRC_Q10,  SRC_DT,   0, SRC_VH,   0, 0);
         6'd39: u = uop(OP_ADD, 1, 1, SRC_Q11,  SRC_DT,   0, SRC_PV,   0, 1);
         default: u = uop(OP_ADD, 1, 0, SRC_DT, SRC_DT,   0, SRC_DT,   0, 1);
      endcase
      return u;
   endfunction

endpackage

@@ design/hvk_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces of the Kalman filter.
interface hvk_req_if import hvk_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DT_W-1:0]   step_time;
   logic [Q16_W-1:0]  vertical_accel;
   logic [Q16_W-1:0]  baro_height;
   logic              baro_valid;

   modport source (output valid, step_time, vertical_accel, baro_height, baro_valid,
                   input ready);
   modport sink   (input valid, step_time, vertical_accel, baro_height, baro_valid,
                   output ready);
endinterface

interface hvk_rsp_if import hvk_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [Q16_W-1:0]  height_est;
   logic [Q16_W-1:0]  velocity_est;
   logic              in_warmup;

   modport source (output valid, height_est, velocity_est, in_warmup, input ready);
   modport sink   (input valid, height_est, velocity_est, in_warmup, output ready);
endinterface

@@ design/height_velocity_kalman_top.sv @@
`timescale 1ns / 1ps
// Top level of the two-state height/velocity Kalman filter.
// Multiply rows run in the shared multiplier and gain rows in the shared divider; without a
// barometer sample the update rows are skipped. One request at a time; the result register
// frees the sequencer, which waits in its output state while an untaken result is held.
// Synchronous active-high reset clears state, covariance, step count, sequencer, response
// valid and configuration registers.
module height_velocity_kalman_top import hvk_pkg::*; #(
   parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   hvk_req_if.sink               req,
   hvk_rsp_if.source             rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int W  = STATE_WIDTH;
   localparam int AW = 2 * W + 4;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_OUT  = 5'b10000
   } seq_state_type;

   typedef logic signed [W-1:0] sval_type;

   hvk_cfg_type   cfg;
   seq_state_type state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic signed [AW-1:0] acc_ff;
   logic [16:0]   step_ff;
   logic          warm_ff, baro_ff;

   sval_type dt_ff, accv_ff, un_ff, hdt2_ff, hs_ff, vs_ff, ph_ff, hv_ff, vh_ff, pv_ff;
   sval_type qh_ff, qv_ff, r_ff, zn_ff, hp_ff, vp_ff, q00_ff, q01_ff, q10_ff, q11_ff;
   sval_type k0_ff, k1_ff, diff_ff, omk_ff, l_ff;

   logic          rsp_valid_ff, warm_out_ff;
   logic [31:0]   hout_ff, vout_ff;

   hvk_uop_type   u;
   sval_type      a_val, b_val, wr_val, one_val;
   logic signed [AW-1:0] base, term, acc_sum;
   logic          is_mul, acc_commit, div_zero, div_commit, wr_en, row_done;
   logic          mul_start, mul_done, div_start, div_done;
   logic signed [2*W-1:0] mul_prod;
   sval_type      div_quo;
   logic          req_take, out_load;

   // request setup values
   logic          warm;
   logic [38:0]   qh_raw, qv_raw;
   logic [31:0]   acc_mag;
   sval_type      acc_sat;
   logic signed [AW-1:0] hs_rnd, vs_rnd;

   function automatic sval_type sat_w(input logic signed [AW-1:0] v);
      logic fits;
      fits = (v[AW-1:W-1] == '0) || (v[AW-1:W-1] == '1);
      if (fits)           return v[W-1:0];
      else if (v[AW-1])   return {1'b1, {(W-1){1'b0}}};
      else                return {1'b0, {(W-1){1'b1}}};
   endfunction

   function automatic logic [31:0] sat32(input logic signed [AW-1:0] v);
      logic fits;
      fits = (v[AW-1:31] == '0) || (v[AW-1:31] == '1);
      if (fits)           return v[31:0];
      else if (v[AW-1])   return 32'h8000_0000;
      else                return 32'h7FFF_FFFF;
   endfunction

   function automatic sval_type src(input hvk_src_type s);
      case (s)
         SRC_DT:   return dt_ff;
         SRC_ACC:  return accv_ff;
         SRC_UN:   return un_ff;
         SRC_HDT2: return hdt2_ff;
         SRC_HS:   return hs_ff;
         SRC_VS:   return vs_ff;
         SRC_PH:   return ph_ff;
         SRC_HV:   return hv_ff;
         SRC_VH:   return vh_ff;
         SRC_PV:   return pv_ff;
         SRC_QH:   return qh_ff;
         SRC_QV:   return qv_ff;
         SRC_R:    return r_ff;
         SRC_ZN:   return zn_ff;
         SRC_HP:   return hp_ff;
         SRC_VP:   return vp_ff;
         SRC_Q00:  return q00_ff;
         SRC_Q01:  return q01_ff;
         SRC_Q10:  return q10_ff;
         SRC_Q11:  return q11_ff;
         SRC_K0:   return k0_ff;
         SRC_K1:   return k1_ff;
         SRC_DIFF: return diff_ff;
         SRC_OMK:  return omk_ff;
         SRC_ONE:  return one_val;
         SRC_L:    return l_ff;
         default:  return '0;
      endcase
   endfunction

   hvk_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .cfg
   );

   hvk_mul #(.W(W)) u_mul (
      .clock, .reset, .start(mul_start), .a(a_val), .b(b_val), .sh25(u.sh25),
      .done(mul_done), .prod(mul_prod)
   );

   hvk_div #(.W(W)) u_div (
      .clock, .reset, .start(div_start), .num(a_val), .den(l_ff),
      .done(div_done), .quo(div_quo)
   );

   assign one_val  = sval_type'(W'(1) << FRAC_W);
   assign req_take = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   // input scaling, dead band and warm-up noise
   always_comb begin
      warm    = step_ff <= {1'b0, cfg.warmup_steps};
      qh_raw  = cfg.height_noise * (warm ? WARMUP_BOOST : 7'd1);
      qv_raw  = cfg.velocity_noise * (warm ? WARMUP_BOOST : 7'd1);
      acc_mag = req.vertical_accel[31] ? -req.vertical_accel : req.vertical_accel;
      acc_sat = sat_w(AW'(signed'({req.vertical_accel, 8'd0})));
   end

   // micro-operation execute
   always_comb begin
      u          = hvk_ucode(pc_ff);
      a_val      = src(u.a);
      b_val      = src(u.b);
      is_mul     = (u.op == OP_MAC) || (u.op == OP_MSC);
      base       = u.clr ? '0 : acc_ff;
      term       = is_mul ? AW'(mul_prod) : AW'(a_val);
      acc_sum    = ((u.op == OP_SUB) || (u.op == OP_MSC)) ? base - term : base + term;
      acc_commit = ((state_ff == S_EXEC) && ((u.op == OP_ADD) || (u.op == OP_SUB)))
                   || ((state_ff == S_MUL) && mul_done);
      div_zero   = (l_ff == '0);
      div_commit = ((state_ff == S_EXEC) && (u.op == OP_DIV) && div_zero)
                   || ((state_ff == S_DIV) && div_done);
      wr_en      = (acc_commit && u.last) || div_commit;
      wr_val     = div_commit ? (div_zero ? '0 : div_quo) : sat_w(acc_sum);
      row_done   = acc_commit || div_commit;
      mul_start  = (state_ff == S_EXEC) && is_mul;
      div_start  = (state_ff == S_EXEC) && (u.op == OP_DIV) && !div_zero;
      out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      case (state_ff)
         S_IDLE: if (req_take) begin
            state_in = S_EXEC;
            pc_in    = '0;
         end
         S_EXEC: begin
            if (mul_start) state_in = S_MUL;
            else if (div_start) state_in = S_DIV;
         end
         S_MUL, S_DIV: ;
         S_OUT: if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (row_done) begin
         if (u.fin) state_in = S_OUT;
         else begin
            state_in = S_EXEC;
            pc_in    = (u.brk && !baro_ff) ? COPY_PC : pc_ff + PC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (req_take && step_ff != STEP_MAX) step_ff <= step_ff + 17'd1;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // filter state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff <= '0; vs_ff <= '0; ph_ff <= '0;
         hv_ff <= '0; vh_ff <= '0; pv_ff <= '0;
      end else if (wr_en) begin
         case (u.dst)
            SRC_HS: hs_ff <= wr_val;
            SRC_VS: vs_ff <= wr_val;
            SRC_PH: ph_ff <= wr_val;
            SRC_HV: hv_ff <= wr_val;
            SRC_VH: vh_ff <= wr_val;
            SRC_PV: pv_ff <= wr_val;
            default: ;
         endcase
      end
   end

   // working registers and accumulator
   always_ff @(posedge clock) begin
      if (acc_commit) acc_ff <= acc_sum;
      if (wr_en) begin
         case (u.dst)
            SRC_HDT2: hdt2_ff <= wr_val;
            SRC_HP:   hp_ff   <= wr_val;
            SRC_VP:   vp_ff   <= wr_val;
            SRC_Q00:  q00_ff  <= wr_val;
            SRC_Q01:  q01_ff  <= wr_val;
            SRC_Q10:  q10_ff  <= wr_val;
            SRC_Q11:  q11_ff  <= wr_val;
            SRC_L:    l_ff    <= wr_val;
            SRC_K0:   k0_ff   <= wr_val;
            SRC_K1:   k1_ff   <= wr_val;
            SRC_DIFF: diff_ff <= wr_val;
            SRC_OMK:  omk_ff  <= wr_val;
            default: ;
         endcase
      end
      if (req_take) begin
         dt_ff   <= sval_type'(W'(req.step_time));
         accv_ff <= acc_sat;
         un_ff   <= (acc_mag < {1'b0, cfg.accel_deadband}) ? '0 : acc_sat;
         zn_ff   <= sat_w(AW'(signed'({req.baro_height, 8'd0})));
         qh_ff   <= sat_w(AW'({1'b0, qh_raw}));
         qv_ff   <= sat_w(AW'({1'b0, qv_raw}));
         r_ff    <= sat_w(AW'({1'b0, cfg.meas_noise}));
         warm_ff <= warm;
         baro_ff <= req.baro_valid;
      end
   end

   // Q24.24 to Q16.16 with rounding
   always_comb begin
      hs_rnd = (AW'(hs_ff) + AW'(9'sd128)) >>> 8;
      vs_rnd = (AW'(vs_ff) + AW'(9'sd128)) >>> 8;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         hout_ff     <= sat32(hs_rnd);
         vout_ff     <= sat32(vs_rnd);
         warm_out_ff <= warm_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.height_est   = hout_ff;
   assign rsp.velocity_est = vout_ff;
   assign rsp.in_warmup    = warm_out_ff;

endmodule

@@ design/hvk_mul.sv @@
`timescale 1ns / 1ps
// Shared signed multiplier: four 32x32 partial products, then rounding shift.
module hvk_mul import hvk_pkg::*; #(
   parameter int W = STATE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [W-1:0]   a,
   input  logic signed [W-1:0]   b,
   input  logic                  sh25,
   output logic                  done,
   output logic signed [2*W-1:0] prod
);

   typedef enum logic [3:0] {
      M_IDLE = 4'b0001,
      M_PP   = 4'b0010,
      M_NEG  = 4'b0100,
      M_RND  = 4'b1000
   } mul_state_type;

   mul_state_type       state_ff, state_in;
   logic [63:0]         a_ff, b_ff;
   logic [1:0]          cnt_ff;
   logic                neg_ff, sh25_ff, done_ff;
   logic [127:0]        p_ff;
   logic signed [2*W-1:0] prod_ff;

   logic [W-1:0]        a_mag, b_mag;
   logic [31:0]         a_part, b_part;
   logic [63:0]         pp;
   logic [6:0]          pp_sft;
   logic signed [127:0] rnd_sum, rnd_sh;

   assign a_mag = a[W-1] ? W'(-a) : W'(a);
   assign b_mag = b[W-1] ? W'(-b) : W'(b);

   // partial product select: low/high halves by the count bits
   always_comb begin
      a_part = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_part = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp     = 64'(a_part) * 64'(b_part);
      pp_sft = 7'd32 * 7'(cnt_ff[1] + cnt_ff[0]);
   end

   // half-lsb rounding then arithmetic shift
   always_comb begin
      rnd_sum = signed'(p_ff) + (sh25_ff ? (128'sd1 <<< 24) : (128'sd1 <<< 23));
      rnd_sh  = sh25_ff ? (rnd_sum >>> 25) : (rnd_sum >>> 24);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         M_IDLE:  if (start) state_in = M_PP;
         M_PP:    if (cnt_ff == 2'd3) state_in = M_NEG;
         M_NEG:   state_in = M_RND;
         M_RND:   state_in = M_IDLE;
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == M_RND);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         M_IDLE: begin
            a_ff    <= 64'(a_mag);
            b_ff    <= 64'(b_mag);
            neg_ff  <= a[W-1] ^ b[W-1];
            sh25_ff <= sh25;
            cnt_ff  <= 2'd0;
            p_ff    <= '0;
         end
         M_PP: begin
            p_ff   <= p_ff + (128'(pp) << pp_sft);
            cnt_ff <= cnt_ff + 2'd1;
         end
         M_NEG: if (neg_ff) p_ff <= -p_ff;
         M_RND: prod_ff <= rnd_sh[2*W-1:0];
         default: ;
      endcase
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

@@ design/hvk_div.sv @@
`timescale 1ns / 1ps
// Restoring divider: (num << 24) / den, one quotient bit a cycle, saturated.
module hvk_div import hvk_pkg::*; #(
   parameter int W = STATE_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] num,
   input  logic signed [W-1:0] den,
   output logic                done,
   output logic signed [W-1:0] quo
);

   localparam int DW = W + FRAC_W;
   localparam int CW = $clog2(DW + 1);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_RUN  = 3'b010,
      D_FIN  = 3'b100
   } div_state_type;

   div_state_type     state_ff, state_in;
   logic [DW-1:0]     n_ff, q_ff;
   logic [W-1:0]      d_ff, rem_ff;
   logic [CW-1:0]     cnt_ff;
   logic              neg_ff, done_ff;
   logic signed [W-1:0] quo_ff;

   logic [W:0]        rem_sh, rem_sub;
   logic              qbit, over;

   // one restoring step
   always_comb begin
      rem_sh  = {rem_ff, n_ff[DW-1]};
      qbit    = rem_sh >= {1'b0, d_ff};
      rem_sub = rem_sh - {1'b0, d_ff};
      over    = |q_ff[DW-1:W-1];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         D_IDLE:  if (start) state_in = D_RUN;
         D_RUN:   if (cnt_ff == CW'(1)) state_in = D_FIN;
         D_FIN:   state_in = D_IDLE;
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == D_FIN);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         D_IDLE: begin
            n_ff   <= DW'(num[W-1] ? W'(-num) : W'(num)) << FRAC_W;
            d_ff   <= den[W-1] ? W'(-den) : W'(den);
            neg_ff <= num[W-1] ^ den[W-1];
            rem_ff <= '0;
            q_ff   <= '0;
            cnt_ff <= CW'(DW);
         end
         D_RUN: begin
            rem_ff <= qbit ? rem_sub[W-1:0] : rem_sh[W-1:0];
            q_ff   <= {q_ff[DW-2:0], qbit};
            n_ff   <= n_ff << 1;
            cnt_ff <= cnt_ff - CW'(1);
         end
         D_FIN: begin
            // saturate the signed quotient to W bits
            if (neg_ff)
               quo_ff <= over ? {1'b1, {(W-1){1'b0}}} : W'(-q_ff[W-1:0]);
            else
               quo_ff <= over ? {1'b0, {(W-1){1'b1}}} : q_ff[W-1:0];
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ design/hvk_csr.sv @@
`timescale 1ns / 1ps
// APB-style configuration registers of the Kalman filter.
module hvk_csr import hvk_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output hvk_cfg_type           cfg
);

   hvk_cfg_type cfg_ff;
   logic [2:0]  idx;
   logic        wr;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   // register write, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.height_noise   <= HEIGHT_NOISE_RST;
         cfg_ff.velocity_noise <= VELOCITY_NOISE_RST;
         cfg_ff.meas_noise     <= MEAS_NOISE_RST;
         cfg_ff.warmup_steps   <= WARMUP_STEPS_RST;
         cfg_ff.accel_deadband <= ACCEL_DEADBAND_RST;
      end else if (wr) begin
         case (idx)
            REG_HEIGHT_NOISE:   cfg_ff.height_noise   <= pwdata;
            REG_VELOCITY_NOISE: cfg_ff.velocity_noise <= pwdata;
            REG_MEAS_NOISE:     cfg_ff.meas_noise     <= pwdata;
            REG_WARMUP_STEPS:   cfg_ff.warmup_steps   <= pwdata[15:0];
            REG_ACCEL_DEADBAND: cfg_ff.accel_deadband <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_HEIGHT_NOISE:   prdata = cfg_ff.height_noise;
         REG_VELOCITY_NOISE: prdata = cfg_ff.velocity_noise;
         REG_MEAS_NOISE:     prdata = cfg_ff.meas_noise;
         REG_WARMUP_STEPS:   prdata = 32'(cfg_ff.warmup_steps);
         REG_ACCEL_DEADBAND: prdata = 32'(cfg_ff.accel_deadband);
         default:            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
